FILE: hdl/rmsr_pkg.sv
// rmsr_pkg: widths, register codes, reset values and shared types of the
// reversing motor soft ramp block. No dependencies.
`default_nettype none

package rmsr_pkg;

  // averaging ring depth (1 to 16)
  localparam int FILTER_TAPS = 6;

  // field widths
  localparam int SAMPLE_W  = 12;
  localparam int CFG_W     = 10;
  localparam int DUTY_W    = 13;
  localparam int CFG_IDX_W = 4;
  localparam int FRAC_W    = 10;
  localparam int PROD_W    = CFG_W + SAMPLE_W;

  // per-tap quotient / remainder of a sample split by the tap count
  localparam int Q_W    = SAMPLE_W;
  localparam int R_W    = (FILTER_TAPS > 1) ? $clog2(FILTER_TAPS) : 1;
  localparam int RSUM_MAX = FILTER_TAPS * (FILTER_TAPS - 1);
  localparam int RSUM_W = (RSUM_MAX > 1) ? $clog2(RSUM_MAX + 1) : 1;
  localparam int POS_W  = (FILTER_TAPS > 1) ? $clog2(FILTER_TAPS) : 1;

  // reciprocal of the tap count, used with one correction step
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_MULT  = (1 << RECIP_SHIFT) / FILTER_TAPS;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int BACK_W      = Q_W + 5;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DUTY_OFFSET = 4'd0,
    REG_RAMP_STEP   = 4'd1,
    REG_RAMP_GAIN   = 4'd2,
    REG_STEADY_GAIN = 4'd3
  } reg_idx_t;

  // register reset values
  localparam logic [CFG_W-1:0] RST_DUTY_OFFSET = 10'd550;
  localparam logic [CFG_W-1:0] RST_RAMP_STEP   = 10'd100;
  localparam logic [CFG_W-1:0] RST_RAMP_GAIN   = 10'd877;
  localparam logic [CFG_W-1:0] RST_STEADY_GAIN = 10'd886;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [CFG_W-1:0] duty_offset;
    logic [CFG_W-1:0] ramp_step;
    logic [CFG_W-1:0] ramp_gain_q10;
    logic [CFG_W-1:0] steady_gain_q10;
  } cfg_t;

  // registered tick with its precomputed terms
  typedef struct packed {
    logic [Q_W-1:0]      quo;
    logic [R_W-1:0]      rem;
    logic [DUTY_W-1:0]   target;
    logic                limit_one_n;
    logic                limit_two_n;
  } item_t;

endpackage

`default_nettype wire

FILE: hdl/rmsr_if.sv
// rmsr channel interfaces: tick input, result output and register write port.
// Depends on rmsr_pkg for field widths.
`default_nettype none

interface rmsr_item_if import rmsr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] adc_sample;
  logic                limit_one_n;
  logic                limit_two_n;

  modport source (output valid, adc_sample, limit_one_n, limit_two_n, input ready);
  modport sink   (input valid, adc_sample, limit_one_n, limit_two_n, output ready);
endinterface

interface rmsr_res_if import rmsr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] pwm_duty;
  logic              drive_left;
  logic              drive_right;
  logic              ramping;

  modport source (output valid, pwm_duty, drive_left, drive_right, ramping, input ready);
  modport sink   (input valid, pwm_duty, drive_left, drive_right, ramping, output ready);
endinterface

interface rmsr_cfg_if import rmsr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/reversing_motor_soft_ramp.sv
// Reversing motor drive with soft ramp, top level.
// A tick is held in the input register until the result register can take it.
// Throughput: one tick per cycle while the result side does not stall; the limit
// is the combinational state update between the input and result registers.
// Reset: synchronous, active low; registers return to defaults, the first tick
// fills the averaging ring with its sample and always runs a reversal.
`default_nettype none

module reversing_motor_soft_ramp import rmsr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rmsr_item_if.sink   in_item,
  rmsr_res_if.source  out_res,
  rmsr_cfg_if.sink    cfg_wr
);

  cfg_t  cfg;
  logic  item_valid;
  item_t item;
  logic  take;

  // configuration registers
  rmsr_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  // input register and sample split
  rmsr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // ramp sequencer and result register
  rmsr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_res    (out_res)
  );

`ifndef SYNTH
  // the bridge never drives both pins
  a_pins_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> !(out_res.drive_left && out_res.drive_right))
    else $error("both bridge pins driven");

  // a finished reversal always leaves the bridge driven
  a_steady_driven: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.ramping) |-> (out_res.drive_left || out_res.drive_right))
    else $error("steady result with bridge off");

  // bridge off only at zero duty inside a reversal
  a_off_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.drive_left && !out_res.drive_right) |->
      (out_res.pwm_duty == '0 && out_res.ramping))
    else $error("bridge off with nonzero duty or outside a reversal");

  // input stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_item.ready |-> (out_res.valid && !out_res.ready))
    else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire

FILE: hdl/rmsr_cfg_regs.sv
// rmsr_cfg_regs: the four configuration registers and their write port.
// Depends on rmsr_pkg and rmsr_cfg_if.
`default_nettype none

module rmsr_cfg_regs import rmsr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rmsr_cfg_if.sink   cfg_wr,
  output cfg_t       cfg
);

  logic [CFG_W-1:0] duty_offset_r;
  logic [CFG_W-1:0] ramp_step_r;
  logic [CFG_W-1:0] ramp_gain_r;
  logic [CFG_W-1:0] steady_gain_r;

  // writes are always taken
  assign cfg_wr.ready = 1'b1;

  // register decode, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_offset_r <= RST_DUTY_OFFSET;
      ramp_step_r   <= RST_RAMP_STEP;
      ramp_gain_r   <= RST_RAMP_GAIN;
      steady_gain_r <= RST_STEADY_GAIN;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_DUTY_OFFSET: duty_offset_r <= cfg_wr.data;
        REG_RAMP_STEP:   ramp_step_r   <= cfg_wr.data;
        REG_RAMP_GAIN:   ramp_gain_r   <= cfg_wr.data;
        REG_STEADY_GAIN: steady_gain_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  assign cfg.duty_offset     = duty_offset_r;
  assign cfg.ramp_step       = ramp_step_r;
  assign cfg.ramp_gain_q10   = ramp_gain_r;
  assign cfg.steady_gain_q10 = steady_gain_r;

endmodule

`default_nettype wire

FILE: hdl/rmsr_in_stage.sv
// rmsr_in_stage: input register; splits the sample by the tap count and
// forms the ramp-up target on the way in. Depends on rmsr_pkg, rmsr_item_if.
`default_nettype none

module rmsr_in_stage import rmsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  rmsr_item_if.sink in_item,
  input  logic      take,
  output logic      item_valid,
  output item_t     item
);

  logic                              valid_r;
  logic                              valid_nxt;
  item_t                             item_r;
  item_t                             item_nxt;
  logic                              accept;
  logic [SAMPLE_W+RECIP_W-1:0]       recip_prod;
  logic [Q_W-1:0]                    q0;
  logic [BACK_W-1:0]                 back;
  logic [BACK_W-1:0]                 rem0;
  logic [PROD_W-1:0]                 target_prod;

  assign in_item.ready = !valid_r || take;
  assign accept        = in_item.valid && in_item.ready;

  // sample / taps by reciprocal, then one correction
  always_comb begin
    recip_prod = (SAMPLE_W+RECIP_W)'(in_item.adc_sample) * (SAMPLE_W+RECIP_W)'(RECIP_MULT);
    q0         = recip_prod[RECIP_SHIFT +: Q_W];
    back       = BACK_W'(q0) * BACK_W'(FILTER_TAPS);
    rem0       = BACK_W'(in_item.adc_sample) - back;
    if (rem0 >= BACK_W'(FILTER_TAPS)) begin
      item_nxt.quo = q0 + Q_W'(1);
      item_nxt.rem = R_W'(rem0 - BACK_W'(FILTER_TAPS));
    end else begin
      item_nxt.quo = q0;
      item_nxt.rem = R_W'(rem0);
    end
    // ramp-up target: offset + gain * raw sample
    target_prod          = PROD_W'(cfg.ramp_gain_q10) * PROD_W'(in_item.adc_sample);
    item_nxt.target      = DUTY_W'(cfg.duty_offset) +
                           DUTY_W'(target_prod[PROD_W-1:FRAC_W]);
    item_nxt.limit_one_n = in_item.limit_one_n;
    item_nxt.limit_two_n = in_item.limit_two_n;
  end

  // holding register occupancy
  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (accept) begin
        item_r <= item_nxt;
      end
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

FILE: hdl/rmsr_core.sv
// rmsr_core: reversal sequencer, averaging ring and duty update, with the
// result register. Depends on rmsr_pkg and rmsr_res_if.
`default_nettype none

module rmsr_core import rmsr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        item_valid,
  input  item_t       item,
  output logic        take,
  rmsr_res_if.source  out_res
);

  typedef enum logic [1:0] {
    PH_STEADY = 2'd0,
    PH_DOWN   = 2'd1,
    PH_UP     = 2'd2
  } phase_t;

  // control state
  phase_t             phase_r, phase_nxt, phase_mid;
  logic [DUTY_W-1:0]  duty_r, duty_nxt;
  logic               wanted_r, wanted_nxt;
  logic               applied_r, applied_nxt;
  logic               drive_r, drive_nxt;
  logic               primed_r, primed_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt, pos_eff;

  // averaging ring, one quotient and remainder per tap
  logic [Q_W-1:0]     ring_q_r   [FILTER_TAPS];
  logic [Q_W-1:0]     ring_q_nxt [FILTER_TAPS];
  logic [Q_W-1:0]     ring_q_ins [FILTER_TAPS];
  logic [R_W-1:0]     ring_r_r   [FILTER_TAPS];
  logic [R_W-1:0]     ring_r_nxt [FILTER_TAPS];
  logic [R_W-1:0]     ring_r_ins [FILTER_TAPS];

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [DUTY_W-1:0]  pwm_r;
  logic               left_r, right_r, ramp_r;

  logic [CFG_W-1:0]   step;
  logic               pick;
  logic [Q_W-1:0]     sum_q;
  logic [RSUM_W-1:0]  sum_r;
  logic [Q_W-1:0]     rem_quo;
  logic [Q_W-1:0]     avg;
  logic [PROD_W-1:0]  steady_prod;
  logic [DUTY_W-1:0]  steady_duty;
  logic [DUTY_W:0]    up_sum;

  assign take = item_valid && (!out_valid_r || out_res.ready);

  // zero step acts as one; switch one wins over switch two
  assign step = (cfg.ramp_step == '0) ? CFG_W'(1) : cfg.ramp_step;
  assign pick = !item.limit_one_n ? 1'b0 : (!item.limit_two_n ? 1'b1 : wanted_r);

  // ring with this sample written at the current position
  always_comb begin
    pos_eff = ({1'b0, pos_r} >= (POS_W+1)'(FILTER_TAPS)) ? '0 : pos_r;
    for (int i = 0; i < FILTER_TAPS; i++) begin
      ring_q_ins[i] = (POS_W'(i) == pos_eff) ? item.quo : ring_q_r[i];
      ring_r_ins[i] = (POS_W'(i) == pos_eff) ? item.rem : ring_r_r[i];
    end
  end

  // average = sum of quotients + (sum of remainders) / taps
  always_comb begin
    sum_q   = '0;
    sum_r   = '0;
    rem_quo = '0;
    for (int i = 0; i < FILTER_TAPS; i++) begin
      sum_q = sum_q + ring_q_ins[i];
      sum_r = sum_r + RSUM_W'(ring_r_ins[i]);
    end
    for (int k = 1; k < FILTER_TAPS; k++) begin
      if (sum_r >= RSUM_W'(k * FILTER_TAPS)) begin
        rem_quo = rem_quo + Q_W'(1);
      end
    end
    avg         = sum_q + rem_quo;
    steady_prod = PROD_W'(cfg.steady_gain_q10) * PROD_W'(avg);
    steady_duty = DUTY_W'(cfg.duty_offset) + DUTY_W'(steady_prod[PROD_W-1:FRAC_W]);
  end

  // next state for one tick
  always_comb begin
    phase_nxt   = phase_r;
    duty_nxt    = duty_r;
    wanted_nxt  = wanted_r;
    applied_nxt = applied_r;
    drive_nxt   = drive_r;
    primed_nxt  = primed_r;
    pos_nxt     = pos_r;
    ring_q_nxt  = ring_q_r;
    ring_r_nxt  = ring_r_r;
    phase_mid   = phase_r;
    up_sum      = {1'b0, duty_r} + (DUTY_W+1)'(step);

    // direction check: first tick forces a reversal
    if (!primed_r) begin
      for (int i = 0; i < FILTER_TAPS; i++) begin
        ring_q_nxt[i] = item.quo;
        ring_r_nxt[i] = item.rem;
      end
      pos_nxt     = '0;
      primed_nxt  = 1'b1;
      wanted_nxt  = pick;
      applied_nxt = !pick;
      phase_mid   = PH_DOWN;
    end else if (phase_r != PH_DOWN && phase_r != PH_UP) begin
      wanted_nxt = pick;
      phase_mid  = (pick != applied_r) ? PH_DOWN : PH_STEADY;
    end

    unique case (phase_mid)
      PH_DOWN: begin
        if (duty_r < DUTY_W'(step)) begin
          duty_nxt    = '0;
          drive_nxt   = 1'b0;
          applied_nxt = wanted_nxt;
          phase_nxt   = PH_UP;
        end else begin
          duty_nxt  = duty_r - DUTY_W'(step);
          phase_nxt = PH_DOWN;
        end
      end
      PH_UP: begin
        drive_nxt = 1'b1;
        if (up_sum > {1'b0, item.target}) begin
          duty_nxt  = item.target;
          phase_nxt = PH_STEADY;
        end else begin
          duty_nxt  = up_sum[DUTY_W-1:0];
          phase_nxt = PH_UP;
        end
      end
      default: begin
        ring_q_nxt = ring_q_ins;
        ring_r_nxt = ring_r_ins;
        pos_nxt    = (pos_eff == POS_W'(FILTER_TAPS - 1)) ? '0 : pos_eff + POS_W'(1);
        duty_nxt   = steady_duty;
        phase_nxt  = PH_STEADY;
      end
    endcase
  end

  // result register occupancy
  always_comb begin
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DOWN;
      duty_r      <= '0;
      wanted_r    <= 1'b0;
      applied_r   <= 1'b0;
      drive_r     <= 1'b0;
      primed_r    <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        phase_r   <= phase_nxt;
        duty_r    <= duty_nxt;
        wanted_r  <= wanted_nxt;
        applied_r <= applied_nxt;
        drive_r   <= drive_nxt;
        primed_r  <= primed_nxt;
        pos_r     <= pos_nxt;
        ring_q_r  <= ring_q_nxt;
        ring_r_r  <= ring_r_nxt;
        pwm_r     <= duty_nxt;
        left_r    <= drive_nxt && applied_nxt;
        right_r   <= drive_nxt && !applied_nxt;
        ramp_r    <= (phase_nxt != PH_STEADY);
      end
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.pwm_duty    = pwm_r;
  assign out_res.drive_left  = left_r;
  assign out_res.drive_right = right_r;
  assign out_res.ramping     = ramp_r;

endmodule

`default_nettype wire

FILE: sim/rmsr_drive_checker.sv
// rmsr_drive_checker: watches the tick, result and register write channels of
// the reversing motor soft ramp, predicts every result and compares it.
// Depends on rmsr_pkg and the rmsr channel interfaces.

module rmsr_drive_checker import rmsr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  rmsr_item_if tick,
  rmsr_res_if  res,
  rmsr_cfg_if  cfg,
  output int   mismatch_count,
  output int   outstanding
);

  typedef enum logic [1:0] {
    PHASE_STEADY = 2'd0,
    PHASE_DOWN   = 2'd1,
    PHASE_UP     = 2'd2
  } ramp_phase_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              left;
    logic              right;
    logic              ramping;
  } drive_out_t;

  // register copies
  int unsigned offset_r;
  int unsigned step_r;
  int unsigned ramp_gain_r;
  int unsigned steady_gain_r;

  // drive state
  int unsigned duty_level;
  ramp_phase_t phase;
  logic        wanted_dir;
  logic        applied_dir;
  logic        drive_on;
  logic        primed;
  int unsigned sample_ring [FILTER_TAPS];
  int unsigned ring_pos;

  drive_out_t drive_expect_q [$];

  // switch one wins, no active switch keeps the current choice
  function automatic logic pick_dir(input logic one_n, input logic two_n, input logic cur);
    if (!one_n) return 1'b0;
    if (!two_n) return 1'b1;
    return cur;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // one control tick through the ramp state machine
  task automatic predict_tick(input logic [SAMPLE_W-1:0] smp, input logic one_n,
                              input logic two_n, output drive_out_t pred);
    int unsigned stp;
    int unsigned tgt;
    int unsigned acc;
    int          i;
    stp = (step_r == 0) ? 1 : step_r;

    // first tick after reset always reverses; later only steady ticks look at switches
    if (!primed) begin
      for (i = 0; i < FILTER_TAPS; i++) sample_ring[i] = 32'(smp);
      ring_pos    = 0;
      primed      = 1'b1;
      wanted_dir  = pick_dir(one_n, two_n, wanted_dir);
      applied_dir = ~wanted_dir;
      phase       = PHASE_DOWN;
    end else if (phase == PHASE_STEADY) begin
      wanted_dir = pick_dir(one_n, two_n, wanted_dir);
      if (wanted_dir != applied_dir) phase = PHASE_DOWN;
    end

    case (phase)
      PHASE_DOWN: begin
        // clamp only when the step would go below zero
        if (duty_level < stp) begin
          duty_level  = 0;
          drive_on    = 1'b0;
          applied_dir = wanted_dir;
          phase       = PHASE_UP;
        end else begin
          duty_level -= stp;
        end
      end
      PHASE_UP: begin
        tgt = offset_r + ((ramp_gain_r * 32'(smp)) >> FRAC_W);
        drive_on = 1'b1;
        duty_level += stp;
        if (duty_level > tgt) begin
          duty_level = tgt;
          phase      = PHASE_STEADY;
        end
      end
      default: begin
        // moving average over the ring
        if (ring_pos >= FILTER_TAPS) ring_pos = 0;
        sample_ring[ring_pos] = 32'(smp);
        ring_pos = (ring_pos + 1 >= FILTER_TAPS) ? 0 : ring_pos + 1;
        acc = 0;
        for (i = 0; i < FILTER_TAPS; i++) acc += sample_ring[i];
        duty_level = offset_r + ((steady_gain_r * (acc / FILTER_TAPS)) >> FRAC_W);
      end
    endcase

    duty_level   = duty_level & ((1 << DUTY_W) - 1);
    pred.duty    = duty_level[DUTY_W-1:0];
    pred.left    = drive_on & applied_dir;
    pred.right   = drive_on & ~applied_dir;
    pred.ramping = (phase != PHASE_STEADY);
  endtask

  always @(posedge clk) begin
    drive_out_t want;
    drive_out_t pred;
    if (!rst_n) begin
      offset_r      = 32'(RST_DUTY_OFFSET);
      step_r        = 32'(RST_RAMP_STEP);
      ramp_gain_r   = 32'(RST_RAMP_GAIN);
      steady_gain_r = 32'(RST_STEADY_GAIN);
      duty_level    = 0;
      phase         = PHASE_DOWN;
      wanted_dir    = 1'b0;
      applied_dir   = 1'b0;
      drive_on      = 1'b0;
      primed        = 1'b0;
      ring_pos      = 0;
      drive_expect_q.delete();
    end else begin
      // result transaction against the oldest expectation
      if (res.valid && res.ready) begin
        if (drive_expect_q.size() == 0) begin
          report_mismatch("unexpected result, pwm_duty", 32'(res.pwm_duty), 0);
        end else begin
          want = drive_expect_q.pop_front();
          if (res.pwm_duty !== want.duty)
            report_mismatch("pwm_duty", 32'(res.pwm_duty), 32'(want.duty));
          if (res.drive_left !== want.left)
            report_mismatch("drive_left", 32'(res.drive_left), 32'(want.left));
          if (res.drive_right !== want.right)
            report_mismatch("drive_right", 32'(res.drive_right), 32'(want.right));
          if (res.ramping !== want.ramping)
            report_mismatch("ramping", 32'(res.ramping), 32'(want.ramping));
        end
      end

      // register write transaction
      if (cfg.valid && cfg.ready) begin
        case (reg_idx_t'(cfg.index))
          REG_DUTY_OFFSET: offset_r      = 32'(cfg.data);
          REG_RAMP_STEP:   step_r        = 32'(cfg.data);
          REG_RAMP_GAIN:   ramp_gain_r   = 32'(cfg.data);
          REG_STEADY_GAIN: steady_gain_r = 32'(cfg.data);
          default: ;
        endcase
      end

      // tick transaction
      if (tick.valid && tick.ready) begin
        predict_tick(tick.adc_sample, tick.limit_one_n, tick.limit_two_n, pred);
        drive_expect_q.push_back(pred);
      end
    end
    outstanding <= drive_expect_q.size();
  end

endmodule

FILE: sim/reversing_motor_soft_ramp_tb.sv
// reversing_motor_soft_ramp_tb: drives ticks and register writes into the
// reversing motor soft ramp, stalls the result side and reports the verdict.
// Depends on rmsr_pkg, the rmsr interfaces, the block and rmsr_drive_checker.

module reversing_motor_soft_ramp_tb;
  import rmsr_pkg::*;

  localparam int RANDOM_TICKS  = 750;
  localparam int RANDOM_PHASES = 6;
  localparam int LONG_HOLD     = 96;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   outstanding;
  int   burst_left;

  rmsr_item_if tick_if ();
  rmsr_res_if  res_if ();
  rmsr_cfg_if  cfg_if ();

  reversing_motor_soft_ramp u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (tick_if),
    .out_res (res_if),
    .cfg_wr  (cfg_if)
  );

  rmsr_drive_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick           (tick_if),
    .res            (res_if),
    .cfg            (cfg_if),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  // one tick transaction, then a gap when the burst runs out
  task automatic send_tick(input logic [SAMPLE_W-1:0] smp, input logic one_n,
                           input logic two_n);
    int gap;
    tick_if.valid       <= 1'b1;
    tick_if.adc_sample  <= smp;
    tick_if.limit_one_n <= one_n;
    tick_if.limit_two_n <= two_n;
    do @(posedge clk); while (!tick_if.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(1, 10);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      tick_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait until every result has come back
  task automatic drain_results();
    tick_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // write all four registers back to back
  task automatic load_settings(input logic [CFG_W-1:0] offs, input logic [CFG_W-1:0] stp,
                               input logic [CFG_W-1:0] rgain, input logic [CFG_W-1:0] sgain);
    reg_idx_t         idx_list [4] = '{REG_DUTY_OFFSET, REG_RAMP_STEP,
                                       REG_RAMP_GAIN, REG_STEADY_GAIN};
    logic [CFG_W-1:0] vals [4];
    int               k;
    vals = '{offs, stp, rgain, sgain};
    for (k = 0; k < 4; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx_list[k];
      cfg_if.data  <= vals[k];
      do @(posedge clk); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // result side: segments of steady, light and heavy stalls, plus a long hold
  initial begin
    int seg;
    int seg_len;
    int mode;
    res_if.ready <= 1'b0;
    seg = 0;
    forever begin
      if (seg % 16 == 3) begin
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        seg_len = $urandom_range(8, 48);
        mode    = $urandom_range(0, 2);
        repeat (seg_len) begin
          case (mode)
            0:       res_if.ready <= 1'b1;
            1:       res_if.ready <= ($urandom_range(0, 3) != 0);
            default: res_if.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
      seg++;
    end
  end

  // stimulus
  initial begin
    int                  r;
    int                  phase_idx;
    logic [SAMPLE_W-1:0] smp;
    logic                one_n;
    logic                two_n;
    logic [CFG_W-1:0]    stp;

    rst_n               <= 1'b0;
    tick_if.valid       <= 1'b0;
    tick_if.adc_sample  <= '0;
    tick_if.limit_one_n <= 1'b1;
    tick_if.limit_two_n <= 1'b1;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= REG_DUTY_OFFSET;
    cfg_if.data         <= '0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: first tick with no switch, ramp up to the offset, extremes
    send_tick('0, 1'b1, 1'b1);
    repeat (6) send_tick('0, 1'b1, 1'b1);
    send_tick('1, 1'b1, 1'b1);
    send_tick('1, 1'b0, 1'b0);

    // zero gains: reversal from 500 lands exactly on zero before clamping
    drain_results();
    load_settings(10'd500, 10'd100, 10'd0, 10'd0);
    send_tick(12'd2048, 1'b1, 1'b1);
    send_tick(12'd1234, 1'b1, 1'b0);
    repeat (5) send_tick('1, 1'b0, 1'b1);
    repeat (6) send_tick(12'd777, 1'b1, 1'b1);

    // random phases: all ones, all zeros, then random settings
    for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
      drain_results();
      case (phase_idx)
        0: load_settings('1, '1, '1, '1);
        1: load_settings('0, '0, '0, '0);
        default: begin
          stp = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 40)) :
                                              CFG_W'($urandom_range(41, 1023));
          load_settings(CFG_W'($urandom_range(0, 1023)), stp,
                        CFG_W'($urandom_range(0, 1023)),
                        CFG_W'($urandom_range(0, 1023)));
        end
      endcase
      repeat (RANDOM_TICKS / RANDOM_PHASES) begin
        // mostly neutral ticks, some direction requests
        r = $urandom_range(0, 99);
        if (r < 75) begin
          one_n = 1'b1; two_n = 1'b1;
        end else if (r < 85) begin
          one_n = 1'b0; two_n = 1'b1;
        end else if (r < 95) begin
          one_n = 1'b1; two_n = 1'b0;
        end else begin
          one_n = 1'b0; two_n = 1'b0;
        end
        r = $urandom_range(0, 9);
        if (r == 0) smp = '0;
        else if (r == 1) smp = '1;
        else smp = SAMPLE_W'($urandom_range(0, 4095));
        if ($urandom_range(0, 59) == 0) drain_results();
        send_tick(smp, one_n, two_n);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: reversing_motor_soft_ramp.f
hdl/rmsr_pkg.sv
hdl/rmsr_if.sv
hdl/rmsr_cfg_regs.sv
hdl/rmsr_in_stage.sv
hdl/rmsr_core.sv
hdl/reversing_motor_soft_ramp.sv
sim/rmsr_drive_checker.sv
sim/reversing_motor_soft_ramp_tb.sv
